// File: rtl/fm_channel_effects_sequencer_macros.svh
// assertion macros for the channel effects sequencer
`ifndef FM_CHANNEL_EFFECTS_SEQUENCER_MACROS_SVH
`define FM_CHANNEL_EFFECTS_SEQUENCER_MACROS_SVH
`ifndef SYNTH
`define FCES_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define FCES_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define FCES_ASSERT(label, clk, rst_n, prop)
`define FCES_ASSERT_RST(label, clk, prop)
`endif
`endif

// File: rtl/fces_pkg.sv
package fces_pkg;

  typedef enum logic [3:0] {
    ACT_TICK      = 4'd0,
    ACT_KEY_OFF   = 4'd1,
    ACT_RETRIG    = 4'd2,
    ACT_KEY_ON    = 4'd3,
    ACT_CAR_ATTEN = 4'd4,
    ACT_MOD_ATTEN = 4'd5,
    ACT_PITCH     = 4'd6,
    ACT_VIBRATO   = 4'd7,
    ACT_SLIDE_UP  = 4'd8,
    ACT_SLIDE_DN  = 4'd9,
    ACT_OP_WRITE  = 4'd10,
    ACT_FEEDBACK  = 4'd11
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_EMIT,
    ST_NEXT
  } state_e;

  typedef struct packed {
    logic [3:0]        action;
    logic [3:0]        channel;
    logic [7:0]        data;
    logic signed [7:0] pitch_delta;
    logic [3:0]        vib_depth;
    logic [3:0]        vib_rate;
    logic [3:0]        step_delay;
    logic              is_carrier;
    logic [7:0]        reg_base;
  } in_item_t;

  typedef struct packed {
    logic [7:0] reg_addr;
    logic [7:0] reg_data;
    logic       last;
  } out_item_t;

  // one channel's state word
  typedef struct packed {
    logic [15:0]       fnum;
    logic signed [7:0] slide_step;
    logic signed [5:0] vib_position;
    logic [3:0]        vib_amplitude;
    logic [3:0]        vib_multiplier;
    logic              vib_falling;
    logic [7:0]        carrier_atten;
    logic [1:0]        atten_step;
    logic [4:0]        atten_countdown;
    logic [4:0]        atten_reload;
  } chan_state_t;

  localparam int unsigned StateW = $bits(chan_state_t);
  localparam int unsigned MaxWr = 5;

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] data;
  } wr_t;

  typedef struct packed {
    logic [2:0]            count;
    wr_t [MaxWr-1:0]       wr;
  } wr_list_t;

  localparam logic [7:0] RegFreqLo   = 8'hA0;
  localparam logic [7:0] RegFreqHi   = 8'hB0;
  localparam logic [7:0] RegFeedback = 8'hC0;
  localparam logic [7:0] RegLevel    = 8'h40;
  localparam logic [15:0] KeyOnBit   = 16'h2000;

  function automatic logic [15:0] note_lookup(input logic [4:0] idx);
    logic [15:0] v;
    case (idx)
      5'd1:  v = 16'h0158;
      5'd2:  v = 16'h0182;
      5'd3:  v = 16'h01B0;
      5'd4:  v = 16'h01CC;
      5'd5:  v = 16'h0203;
      5'd6:  v = 16'h0241;
      5'd7:  v = 16'h0286;
      5'd9:  v = 16'h016A;
      5'd10: v = 16'h0196;
      5'd11: v = 16'h01C7;
      5'd12: v = 16'h01E4;
      5'd13: v = 16'h021E;
      5'd14: v = 16'h025F;
      5'd15: v = 16'h02A8;
      5'd17: v = 16'h0147;
      5'd18: v = 16'h016E;
      5'd19: v = 16'h019A;
      5'd20: v = 16'h01B5;
      5'd21: v = 16'h01E9;
      5'd22: v = 16'h0224;
      5'd23: v = 16'h0266;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] expand_note(input logic [7:0] b);
    return note_lookup(b[4:0]) + {3'b000, b[7:5], 10'd0};
  endfunction

  function automatic logic [7:0] op_offset(input logic [3:0] ch, input logic car);
    logic [7:0] m;
    case (ch)
      4'd0: m = 8'h00;
      4'd1: m = 8'h01;
      4'd2: m = 8'h02;
      4'd3: m = 8'h08;
      4'd4: m = 8'h09;
      4'd5: m = 8'h0A;
      4'd6: m = 8'h10;
      4'd7: m = 8'h11;
      4'd8: m = 8'h12;
      default: m = 8'h00;
    endcase
    return car ? m + 8'h03 : m;
  endfunction

endpackage

// File: rtl/fces_ram.sv
module fces_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fces_exec.sv
module fces_exec (
  input  fces_pkg::in_item_t    item_i,
  input  logic [3:0]            ch_i,
  input  fces_pkg::chan_state_t st_i,
  output fces_pkg::chan_state_t st_o,
  output fces_pkg::wr_list_t    wr_o
);
  import fces_pkg::*;

  logic [15:0]       w;
  logic [15:0]       vw;
  logic signed [6:0] pos;
  logic signed [5:0] pnew;
  logic signed [9:0] d;
  logic              fall;
  logic [4:0]        cd;
  logic signed [9:0] cur;
  logic [7:0]        cur8;
  logic [2:0]        n;

  always_comb begin
    st_o = st_i;
    wr_o = '0;
    n = '0;
    w = '0;
    vw = '0;
    pos = '0;
    pnew = '0;
    d = '0;
    fall = st_i.vib_falling;
    cd = '0;
    cur = '0;
    cur8 = '0;
    case (action_e'(item_i.action))
      ACT_TICK: begin
        if (st_i.slide_step != 8'sd0) begin
          w = st_i.fnum + {{8{st_i.slide_step[7]}}, st_i.slide_step};
          st_o.fnum = w;
          wr_o.wr[0] = '{RegFreqLo + {4'd0, ch_i}, w[7:0]};
          wr_o.wr[1] = '{RegFreqHi + {4'd0, ch_i}, w[15:8]};
          n = 3'd2;
        end else if (st_i.vib_multiplier != 4'd0 && (st_i.fnum & KeyOnBit) != 16'd0) begin
          if ($signed({st_i.vib_position[5], st_i.vib_position})
              >= $signed({3'b000, st_i.vib_amplitude}))
            fall = 1'b1;
          else if (st_i.vib_position <= 6'sd0)
            fall = 1'b0;
          pos = {st_i.vib_position[5], st_i.vib_position} + (fall ? -7'sd1 : 7'sd1);
          pnew = pos[5:0];
          st_o.vib_falling = fall;
          st_o.vib_position = pnew;
          d = ({{4{pnew[5]}}, pnew} - $signed({7'd0, st_i.vib_amplitude[3:1]}))
              * $signed({6'd0, st_i.vib_multiplier});
          vw = st_i.fnum + {{6{d[9]}}, d};
          wr_o.wr[0] = '{RegFreqLo + {4'd0, ch_i}, vw[7:0]};
          wr_o.wr[1] = '{RegFreqHi + {4'd0, ch_i}, vw[15:8]};
          n = 3'd2;
        end
        if (st_i.atten_step != 2'd0) begin
          cd = st_i.atten_countdown - 5'd1;
          st_o.atten_countdown = cd;
          if (cd == 5'd0) begin
            st_o.atten_countdown = st_i.atten_reload;
            cur = $signed({2'b00, st_i.carrier_atten})
                  + (st_i.atten_step == 2'd1 ? 10'sd1 : -10'sd1);
            if (cur > 10'sd63) begin
              cur = 10'sd63;
              st_o.atten_step = 2'd0;
            end else if (cur < 10'sd0) begin
              cur = 10'sd0;
              st_o.atten_step = 2'd0;
            end
            cur8 = cur[7:0];
            st_o.carrier_atten = cur8;
            wr_o.wr[n] = '{RegLevel + op_offset(ch_i, 1'b1), cur8};
            n = n + 3'd1;
          end
        end
      end
      ACT_KEY_OFF, ACT_KEY_ON: begin
        w = expand_note(item_i.data);
        if (item_i.action == ACT_KEY_ON) w = w | KeyOnBit;
        st_o.fnum = w;
        wr_o.wr[0] = '{RegFreqLo + {4'd0, ch_i}, w[7:0]};
        wr_o.wr[1] = '{RegFreqHi + {4'd0, ch_i}, w[15:8]};
        n = 3'd2;
      end
      ACT_RETRIG: begin
        w = expand_note(item_i.data);
        st_o.vib_falling = 1'b0;
        st_o.vib_position = '0;
        st_o.fnum = w | KeyOnBit;
        wr_o.wr[0] = '{RegFreqLo + {4'd0, ch_i}, w[7:0]};
        wr_o.wr[1] = '{RegFreqHi + {4'd0, ch_i}, w[15:8]};
        wr_o.wr[2] = '{RegFreqLo + {4'd0, ch_i}, w[7:0]};
        wr_o.wr[3] = '{RegFreqHi + {4'd0, ch_i}, w[15:8] | 8'h20};
        n = 3'd4;
      end
      ACT_CAR_ATTEN: begin
        st_o.atten_step = 2'd0;
        st_o.carrier_atten = item_i.data;
        wr_o.wr[0] = '{RegLevel + op_offset(ch_i, 1'b1), item_i.data};
        n = 3'd1;
      end
      ACT_MOD_ATTEN: begin
        wr_o.wr[0] = '{RegLevel + op_offset(ch_i, 1'b0), item_i.data};
        n = 3'd1;
      end
      ACT_PITCH: st_o.slide_step = item_i.pitch_delta;
      ACT_VIBRATO: begin
        st_o.vib_amplitude = item_i.vib_depth;
        st_o.vib_multiplier = item_i.vib_rate;
      end
      ACT_SLIDE_UP, ACT_SLIDE_DN: begin
        st_o.atten_step = (item_i.action == ACT_SLIDE_UP) ? 2'd1 : 2'd3;
        st_o.atten_countdown = {1'b0, item_i.step_delay} + 5'd1;
        st_o.atten_reload = {1'b0, item_i.step_delay} + 5'd1;
      end
      ACT_OP_WRITE: begin
        wr_o.wr[0] = '{item_i.reg_base + op_offset(ch_i, item_i.is_carrier), item_i.data};
        n = 3'd1;
      end
      ACT_FEEDBACK: begin
        wr_o.wr[0] = '{RegFeedback + {4'd0, ch_i}, item_i.data};
        n = 3'd1;
      end
      default: ;
    endcase
    wr_o.count = n;
  end

endmodule

// File: rtl/fm_channel_effects_sequencer.sv
// Channel effects sequencer: per-channel state sits in one synchronous RAM
// entry per channel. A command passes through a read step, an execute step,
// one emit step per register write and a closing step before idle; a command
// that is ignored is dropped without leaving idle. A tick walks the channels
// one after another through the same read-modify-write path, ST_READ to
// ST_NEXT for each channel, and returns to idle after the last channel.
// Each write waits in a holding register so that the final write of an item
// carries last; results may be held back by out_stall_i without loss, which
// adds cycles. Reset does not clear the RAM itself; entries are zeroed by a
// sweep over all entries after reset, during which no item is taken.
module fm_channel_effects_sequencer #(
  parameter int unsigned NUM_CHANNELS = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fces_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fces_pkg::out_item_t out_data_o
);
  import fces_pkg::*;

  localparam int unsigned AddrW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [3:0] LastCh = 4'(NUM_CHANNELS - 1);

  state_e      state_q, state_d;
  in_item_t    item_q;
  logic [3:0]  ch_q, ch_d;
  logic        clr_q;
  logic [3:0]  clr_ch_q;
  chan_state_t st_rd, st_new;
  wr_list_t    wl, wl_q;
  logic [2:0]  idx_q, idx_d;
  logic        we;
  logic [AddrW-1:0] waddr, raddr;
  chan_state_t wdata;
  logic        accept;
  logic        out_valid_q;
  out_item_t   out_q;
  logic        last_ch;
  logic        out_free;
  logic        emit_go;
  logic        flush_go;
  logic        pend_valid_q;
  wr_t         pend_q;

  fces_ram #(.Width(StateW), .Depth(NUM_CHANNELS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (st_rd)
  );

  fces_exec u_exec (
    .item_i (item_q),
    .ch_i   (ch_q),
    .st_i   (st_rd),
    .st_o   (st_new),
    .wr_o   (wl)
  );

  assign in_stall_o = clr_q || (state_q != ST_IDLE);
  assign accept = in_valid_i && !in_stall_o;
  assign last_ch = (item_q.action != ACT_TICK) || (ch_q == LastCh);

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit_go  = !pend_valid_q || out_free;
  assign flush_go = (state_q == ST_NEXT) && last_ch && pend_valid_q && out_free;

  assign raddr = AddrW'(ch_q);
  assign we    = clr_q || (state_q == ST_EXEC);
  assign waddr = clr_q ? AddrW'(clr_ch_q) : AddrW'(ch_q);
  assign wdata = clr_q ? '0 : st_new;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.action == ACT_TICK)
            state_d = ST_READ;
          else if (in_data_i.channel < 4'(NUM_CHANNELS) && in_data_i.action <= ACT_FEEDBACK)
            state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: state_d = (wl.count != 3'd0) ? ST_EMIT : ST_NEXT;
      ST_EMIT: begin
        if (emit_go)
          state_d = (idx_q + 3'd1 == wl_q.count) ? ST_NEXT : ST_EMIT;
      end
      ST_NEXT: begin
        if (!last_ch)
          state_d = ST_READ;
        else if (!pend_valid_q || out_free)
          state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ch_d = ch_q;
    idx_d = idx_q;
    if (state_q == ST_IDLE && accept)
      ch_d = (in_data_i.action == ACT_TICK) ? 4'd0 : in_data_i.channel;
    if (state_q == ST_NEXT && !last_ch)
      ch_d = ch_q + 4'd1;
    if (state_q == ST_EXEC)
      idx_d = '0;
    if (state_q == ST_EMIT && emit_go)
      idx_d = idx_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ch_q         <= '0;
      idx_q        <= '0;
      clr_q        <= 1'b1;
      clr_ch_q     <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      idx_q   <= idx_d;
      if (clr_q) begin
        clr_ch_q <= clr_ch_q + 4'd1;
        if (clr_ch_q == LastCh) clr_q <= 1'b0;
      end
      if (state_q == ST_EMIT && emit_go)
        pend_valid_q <= 1'b1;
      else if (flush_go)
        pend_valid_q <= 1'b0;
      if ((state_q == ST_EMIT && emit_go && pend_valid_q) || flush_go)
        out_valid_q <= 1'b1;
      else if (!out_stall_i)
        out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept) item_q <= in_data_i;
    if (state_q == ST_EXEC) wl_q <= wl;
    if (state_q == ST_EMIT && emit_go) begin
      pend_q <= wl_q.wr[idx_q];
      if (pend_valid_q) begin
        out_q.reg_addr <= pend_q.addr;
        out_q.reg_data <= pend_q.data;
        out_q.last     <= 1'b0;
      end
    end
    if (flush_go) begin
      // held write is the final one of the item
      out_q.reg_addr <= pend_q.addr;
      out_q.reg_data <= pend_q.data;
      out_q.last     <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `include "fm_channel_effects_sequencer_macros.svh"

  `FCES_ASSERT(a_no_accept_busy, clk_i, rst_ni, (state_q != ST_IDLE) |-> !accept)
  `FCES_ASSERT(a_hold_out, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> out_valid_o)
  `FCES_ASSERT(a_emit_in_range, clk_i, rst_ni, (state_q == ST_EMIT) |-> (idx_q < wl_q.count))
  `FCES_ASSERT(a_idle_flushed, clk_i, rst_ni, (state_q == ST_IDLE) |-> !pend_valid_q)
  `FCES_ASSERT_RST(a_clear_idle, clk_i, (rst_ni && clr_q) |-> (state_q == ST_IDLE))

endmodule

// File: bench/tb_fm_channel_effects_sequencer.sv
module tb_fm_channel_effects_sequencer;
  import fces_pkg::*;

  localparam int NCH = 9;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;

  fm_channel_effects_sequencer #(.NUM_CHANNELS(NCH)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  class reg_write_board;
    out_item_t pending[$];
    int errors = 0;
    int writes_seen = 0;
    logic [15:0] freq[NCH];
    logic signed [7:0] slide[NCH];
    logic signed [5:0] vpos[NCH];
    logic [3:0] vamp[NCH];
    logic [3:0] vmul[NCH];
    logic vfall[NCH];
    logic [7:0] catt[NCH];
    logic [1:0] astep[NCH];
    logic [4:0] acnt[NCH];
    logic [4:0] arel[NCH];
    out_item_t burst[$];

    function new();
      for (int i = 0; i < NCH; i++) begin
        freq[i] = '0; slide[i] = '0; vpos[i] = '0; vamp[i] = '0; vmul[i] = '0;
        vfall[i] = 1'b0; catt[i] = '0; astep[i] = '0; acnt[i] = '0; arel[i] = '0;
      end
    endfunction

    function void put(logic [7:0] a, logic [7:0] d);
      out_item_t o;
      o.reg_addr = a;
      o.reg_data = d;
      o.last = 1'b0;
      burst.push_back(o);
    endfunction

    function void put_freq(int ch, logic [15:0] w);
      put(8'hA0 + 8'(ch), w[7:0]);
      put(8'hB0 + 8'(ch), w[15:8]);
    endfunction

    function logic [15:0] note_word(logic [7:0] b);
      logic [15:0] tbl[24];
      int idx;
      tbl = '{16'h0000, 16'h0158, 16'h0182, 16'h01B0, 16'h01CC, 16'h0203, 16'h0241,
              16'h0286, 16'h0000, 16'h016A, 16'h0196, 16'h01C7, 16'h01E4, 16'h021E,
              16'h025F, 16'h02A8, 16'h0000, 16'h0147, 16'h016E, 16'h019A, 16'h01B5,
              16'h01E9, 16'h0224, 16'h0266};
      idx = b[4:0];
      if (idx >= 24) idx = 0;
      return tbl[idx] + {3'd0, b[7:5], 10'd0};
    endfunction

    function logic [7:0] chan_off(int ch, logic car);
      logic [7:0] m[NCH];
      m = '{8'h00, 8'h01, 8'h02, 8'h08, 8'h09, 8'h0A, 8'h10, 8'h11, 8'h12};
      return car ? m[ch] + 8'h03 : m[ch];
    endfunction

    function void tick_one(int ch);
      int p, amp, d, cur;
      if (slide[ch] != 0) begin
        freq[ch] = freq[ch] + 16'(int'(slide[ch]));
        put_freq(ch, freq[ch]);
      end else if (vmul[ch] != 0 && freq[ch][13]) begin
        p = vpos[ch];
        amp = vamp[ch];
        if (p >= amp) vfall[ch] = 1'b1;
        else if (p <= 0) vfall[ch] = 1'b0;
        p += vfall[ch] ? -1 : 1;
        p = ((p + 32) & 63) - 32;
        vpos[ch] = 6'(p);
        d = (p - (amp >> 1)) * int'(vmul[ch]);
        put_freq(ch, freq[ch] + 16'(d));
      end
      if (astep[ch] != 0) begin
        acnt[ch] = acnt[ch] - 5'd1;
        if (acnt[ch] == 0) begin
          acnt[ch] = arel[ch];
          cur = int'(catt[ch]) + (astep[ch] == 2'd1 ? 1 : -1);
          if (cur > 63) begin
            cur = 63; astep[ch] = '0;
          end else if (cur < 0) begin
            cur = 0; astep[ch] = '0;
          end
          catt[ch] = 8'(cur);
          put(8'h40 + chan_off(ch, 1'b1), 8'(cur));
        end
      end
    endfunction

    function void note_input(in_item_t it);
      int ch;
      logic [15:0] w;
      burst.delete();
      ch = it.channel;
      if (action_e'(it.action) == ACT_TICK) begin
        for (int i = 0; i < NCH; i++) tick_one(i);
      end else if (ch < NCH) begin
        case (it.action)
          ACT_KEY_OFF: begin
            w = note_word(it.data); put_freq(ch, w); freq[ch] = w;
          end
          ACT_RETRIG: begin
            vfall[ch] = 1'b0; vpos[ch] = '0;
            w = note_word(it.data); put_freq(ch, w);
            w = w | 16'h2000; put_freq(ch, w); freq[ch] = w;
          end
          ACT_KEY_ON: begin
            w = note_word(it.data) | 16'h2000; put_freq(ch, w); freq[ch] = w;
          end
          ACT_CAR_ATTEN: begin
            astep[ch] = '0; put(8'h40 + chan_off(ch, 1'b1), it.data); catt[ch] = it.data;
          end
          ACT_MOD_ATTEN: put(8'h40 + chan_off(ch, 1'b0), it.data);
          ACT_PITCH: slide[ch] = it.pitch_delta;
          ACT_VIBRATO: begin
            vamp[ch] = it.vib_depth; vmul[ch] = it.vib_rate;
          end
          ACT_SLIDE_UP, ACT_SLIDE_DN: begin
            astep[ch] = (it.action == ACT_SLIDE_UP) ? 2'd1 : 2'd3;
            acnt[ch] = 5'(it.step_delay) + 5'd1;
            arel[ch] = acnt[ch];
          end
          ACT_OP_WRITE: put(it.reg_base + chan_off(ch, it.is_carrier), it.data);
          ACT_FEEDBACK: put(8'hC0 + 8'(ch), it.data);
          default: ;
        endcase
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) pending.push_back(burst[i]);
    endfunction

    function void check_write(out_item_t got);
      out_item_t exp_w;
      writes_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected write addr %h data %h last %b", $time,
                 got.reg_addr, got.reg_data, got.last);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.reg_addr !== exp_w.reg_addr)
        $display("%0t: reg_addr expected %h actual %h", $time, exp_w.reg_addr, got.reg_addr);
      if (got.reg_data !== exp_w.reg_data)
        $display("%0t: reg_data expected %h actual %h", $time, exp_w.reg_data, got.reg_data);
      if (got.last !== exp_w.last)
        $display("%0t: last expected %b actual %b", $time, exp_w.last, got.last);
      if (got !== exp_w) errors++;
    endfunction
  endclass

  reg_write_board board;
  int cycles = 0;
  bit calm = 1'b0;
  int items_sent = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_fm_channel_effects_sequencer failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_write(out_data_o);
    out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 37);
  end

  task automatic send(in_item_t it);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_input(it);
    items_sent++;
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  function automatic in_item_t cmd(action_e a, int ch, int d);
    in_item_t it;
    it = rand_item();
    it.action = a;
    it.channel = 4'(ch);
    it.data = 8'(d);
    return it;
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  initial begin
    in_item_t it;
    int r;
    board = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(cmd(ACT_KEY_ON, 0, 8'hFF));
    send(cmd(ACT_KEY_OFF, 8, 8'h00));
    send(cmd(ACT_RETRIG, 1, 8'h19));
    send(cmd(ACT_RETRIG, 2, 8'hE7));
    send(cmd(ACT_CAR_ATTEN, 3, 8'h45));
    send(cmd(ACT_MOD_ATTEN, 4, 8'hFF));
    it = cmd(ACT_PITCH, 5, 0); it.pitch_delta = 8'sh80; send(it);
    send(cmd(ACT_KEY_ON, 5, 8'h00));
    it = cmd(ACT_VIBRATO, 1, 0); it.vib_depth = 4'd0; it.vib_rate = 4'd15; send(it);
    it = cmd(ACT_VIBRATO, 2, 0); it.vib_depth = 4'd15; it.vib_rate = 4'd1; send(it);
    it = cmd(ACT_SLIDE_UP, 3, 0); it.step_delay = 4'd0; send(it);
    it = cmd(ACT_SLIDE_DN, 6, 0); it.step_delay = 4'd15; send(it);
    it = cmd(ACT_OP_WRITE, 8, 8'hAA); it.is_carrier = 1'b1; it.reg_base = 8'hFF; send(it);
    it = cmd(ACT_OP_WRITE, 0, 8'h55); it.is_carrier = 1'b0; it.reg_base = 8'h20; send(it);
    send(cmd(ACT_FEEDBACK, 7, 8'h3C));
    send(cmd(ACT_FEEDBACK, 9, 8'h01));
    send(cmd(ACT_KEY_ON, 15, 8'h01));
    send(cmd(action_e'(4'd12), 0, 8'h01));
    send(cmd(action_e'(4'd15), 2, 8'h01));
    it = cmd(ACT_PITCH, 4, 0); it.pitch_delta = 8'sd127; send(it);
    for (int i = 0; i < 4; i++) send(cmd(ACT_TICK, $urandom_range(15), 0));

    // sender holds off until every write is out
    drain();

    for (int n = 0; n < 95; n++) begin
      calm = (n >= 40 && n < 70);
      r = $urandom_range(99);
      it = rand_item();
      if (r < 30) it.action = ACT_TICK;
      else if (r < 92) begin
        it.action = 4'($urandom_range(11));
        it.channel = 4'($urandom_range(8));
      end
      send(it);
    end
    calm = 1'b0;
    drain();
    $display("%0d inputs sent, %0d register writes checked: notes, slides, vibrato,",
             items_sent, board.writes_seen);
    $display("attenuation ramps, operator writes and ignored commands");
    if (board.errors == 0 && board.pending.size() == 0)
      $display("tb_fm_channel_effects_sequencer passed");
    else
      $display("tb_fm_channel_effects_sequencer failed");
    $finish;
  end
endmodule
